// ===== hdl/rau_pkg.sv =====
// Shared types, constants and codes for the rational arithmetic unit.
package rau_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int DW          = 2 * VALUE_WIDTH;
	localparam int KW          = $clog2(DW) + 1;
	localparam int CW          = $clog2(DW + 1);

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIVZ = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MUL_P0 = 2'd0,
		MUL_P1 = 2'd1,
		MUL_P2 = 2'd2
	} mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_SUM,
		S_CHK,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]                    operation;
		logic signed [VALUE_WIDTH-1:0] lhs_numerator;
		logic [VALUE_WIDTH-2:0]        lhs_denominator;
		logic signed [VALUE_WIDTH-1:0] rhs_numerator;
		logic [VALUE_WIDTH-2:0]        rhs_denominator;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] result_numerator;
		logic [VALUE_WIDTH-2:0]        result_denominator;
		logic                          is_equal;
		status_t                       status;
	} result_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum_en;
		logic     gcd_step;
		logic     div_load;
		logic     div_den;
		logic     div_step;
		logic     num_store;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic special;
		logic gcd_done;
		logic div_done;
	} stat_t;

endpackage

// ===== hdl/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit.
//
// Usage:
//  - Input channel item/item_valid/item_stall carries an operation and two
//    fractions; a transfer happens when item_valid is high and item_stall low.
//  - Output channel result/result_valid/result_stall gives one result per
//    item: the reduced fraction with the sign on the numerator, an equality
//    flag for compares, and a status (ok, division by zero, overflow).
//  - One item is worked on at a time. After a transfer: three products on the
//    shared multiplier, then the raw fraction is formed and checked, then the
//    binary GCD loop (one step a cycle) and two shift-subtract divisions by
//    the GCD, first of the numerator and then of the denominator. Compares
//    and special cases skip the GCD loop and the divisions.
//  - The result sits in an output register; while it waits under
//    result_stall, the next item may be taken and worked on. The finished
//    item then holds until the register frees.
//  - arst_n clears the sequencer and the output valid flag at once; the
//    block comes out of reset idle and ready.
module rational_arithmetic_unit_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  rau_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output rau_pkg::result_t result
);

	rau_pkg::cmd_t  cmd;
	rau_pkg::stat_t stat;

	// sequencer: owns the handshakes and steps the datapath
	rau_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	// datapath: operands, products, GCD, divider and result register
	rau_dpath u_dpath (
		.clk    (clk),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

// ===== hdl/rau_ctrl.sv =====
// Sequencing state machine and output valid flag of the rational arithmetic unit.
module rau_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	output logic           result_valid,
	input  logic           result_stall,
	input  rau_pkg::stat_t stat,
	output rau_pkg::cmd_t  cmd
);

	rau_pkg::state_t state_q, state_nx;
	logic            out_valid_q;
	logic            out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign item_stall   = (state_q != rau_pkg::S_IDLE);
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rau_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			rau_pkg::S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_nx = rau_pkg::S_MUL0;
				end
			end
			rau_pkg::S_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rau_pkg::MUL_P0;
				state_nx    = rau_pkg::S_MUL1;
			end
			rau_pkg::S_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rau_pkg::MUL_P1;
				state_nx    = rau_pkg::S_MUL2;
			end
			rau_pkg::S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rau_pkg::MUL_P2;
				state_nx    = rau_pkg::S_SUM;
			end
			rau_pkg::S_SUM: begin
				cmd.sum_en = 1'b1;
				state_nx   = rau_pkg::S_CHK;
			end
			rau_pkg::S_CHK: begin
				state_nx = stat.special ? rau_pkg::S_FIN : rau_pkg::S_GCD;
			end
			rau_pkg::S_GCD: begin
				if (stat.gcd_done) begin
					cmd.div_load = 1'b1;
					state_nx     = rau_pkg::S_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			rau_pkg::S_DIVN: begin
				if (stat.div_done) begin
					cmd.num_store = 1'b1;
					cmd.div_load  = 1'b1;
					cmd.div_den   = 1'b1;
					state_nx      = rau_pkg::S_DIVD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			rau_pkg::S_DIVD: begin
				if (stat.div_done) begin
					state_nx = rau_pkg::S_FIN;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			rau_pkg::S_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = rau_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = rau_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/rau_dpath.sv =====
// Datapath: operand capture, shared multiplier, binary GCD, shift-subtract divider, result register.
module rau_dpath (
	input  logic             clk,
	input  rau_pkg::item_t   item,
	input  rau_pkg::cmd_t    cmd,
	output rau_pkg::stat_t   stat,
	output rau_pkg::result_t result
);

	localparam int W  = rau_pkg::VALUE_WIDTH;
	localparam int DW = rau_pkg::DW;
	localparam logic [DW-1:0] NUM_POS_LIM = (DW'(1) << (W - 1)) - DW'(1);
	localparam logic [DW-1:0] NUM_NEG_LIM = DW'(1) << (W - 1);

	// operand registers
	logic [2:0]            op_q;
	logic signed [W-1:0]   a_q, c_q;
	logic [W-2:0]          b_q, d_q;

	// products
	logic signed [W:0]     mx, my;
	logic signed [2*W+1:0] mprod;
	logic signed [DW-1:0]  p0_q, p1_q, p2_q;

	// raw fraction
	logic signed [DW-1:0]  rn, rd;
	logic                  neg_q, rn_zero_q, rd_zero_q;
	logic [DW-1:0]         nm_q, dm_q;

	// gcd
	logic [DW-1:0]         u_q, v_q, g_q;
	logic [rau_pkg::KW-1:0] k_q;

	// divider
	logic [DW:0]           rem_q, trial;
	logic [DW-1:0]         quo_q, qn_q;
	logic [rau_pkg::CW-1:0] cnt_q;
	logic                  fits;

	rau_pkg::result_t      res_nx;

	always_comb begin
		mx = '0;
		my = '0;
		case (cmd.mul_sel)
			rau_pkg::MUL_P0: begin
				mx = {a_q[W-1], a_q};
				my = (op_q == rau_pkg::OP_MUL) ? {c_q[W-1], c_q} : {2'b00, d_q};
			end
			rau_pkg::MUL_P1: begin
				mx = {c_q[W-1], c_q};
				my = {2'b00, b_q};
			end
			rau_pkg::MUL_P2: begin
				mx = {2'b00, b_q};
				my = (op_q == rau_pkg::OP_DIV) ? {c_q[W-1], c_q} : {2'b00, d_q};
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
		mprod = mx * my;
	end

	always_comb begin
		case (op_q)
			rau_pkg::OP_ADD: rn = p0_q + p1_q;
			rau_pkg::OP_SUB: rn = p0_q - p1_q;
			default:         rn = p0_q;
		endcase
		rd = p2_q;
	end

	assign trial = {rem_q[DW-1:0], quo_q[DW-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= item.operation;
			a_q  <= item.lhs_numerator;
			b_q  <= item.lhs_denominator;
			c_q  <= item.rhs_numerator;
			d_q  <= item.rhs_denominator;
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				rau_pkg::MUL_P0: p0_q <= mprod[DW-1:0];
				rau_pkg::MUL_P1: p1_q <= mprod[DW-1:0];
				default:         p2_q <= mprod[DW-1:0];
			endcase
		end
		if (cmd.sum_en) begin
			neg_q     <= rn[DW-1] ^ rd[DW-1];
			rn_zero_q <= (rn == '0);
			rd_zero_q <= (rd == '0);
			nm_q      <= rn[DW-1] ? DW'(-rn) : DW'(rn);
			dm_q      <= rd[DW-1] ? DW'(-rd) : DW'(rd);
			u_q       <= rn[DW-1] ? DW'(-rn) : DW'(rn);
			v_q       <= rd[DW-1] ? DW'(-rd) : DW'(rd);
			k_q       <= '0;
		end
		// Stein step: strip common twos, then halve an even side or subtract
		if (cmd.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
		if (cmd.div_load) begin
			g_q   <= (u_q | v_q) << k_q;
			quo_q <= cmd.div_den ? dm_q : nm_q;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, g_q}) begin
				rem_q <= trial - {1'b0, g_q};
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.num_store) begin
			qn_q <= quo_q;
		end
		if (cmd.out_load) begin
			result <= res_nx;
		end
	end

	assign stat.special  = (op_q >= rau_pkg::OP_CMP) || rd_zero_q || rn_zero_q;
	assign stat.gcd_done = (u_q == '0) || (v_q == '0);
	assign stat.div_done = (cnt_q == rau_pkg::CW'(DW));

	assign fits = (neg_q ? (qn_q <= NUM_NEG_LIM) : (qn_q <= NUM_POS_LIM))
		&& (quo_q <= NUM_POS_LIM);

	always_comb begin
		res_nx = '0;
		if (op_q == rau_pkg::OP_CMP) begin
			res_nx.is_equal = (a_q == c_q) && (b_q == d_q);
		end else if (op_q > rau_pkg::OP_CMP) begin
			res_nx = '0;
		end else if (rd_zero_q) begin
			res_nx.status = rau_pkg::ST_DIVZ;
		end else if (rn_zero_q) begin
			res_nx.result_denominator = (W-1)'(1);
		end else if (!fits) begin
			res_nx.status = rau_pkg::ST_OVF;
		end else begin
			res_nx.result_numerator   = neg_q ? -qn_q[W-1:0] : qn_q[W-1:0];
			res_nx.result_denominator = quo_q[W-2:0];
		end
	end

endmodule

// ===== hdl/rau_checker.sv =====
// Port-level assertions for the rational arithmetic unit, with the bind to the top level.
module rau_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input rau_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input rau_pkg::result_t result
);

	// a transfer starts work, so the input side must stall next
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after a transfer");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == rau_pkg::ST_DIVZ |->
		result.result_numerator == '0 && result.result_denominator == '0)
		else $error("error result carries a fraction");

	a_equal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_equal |->
		result.status == rau_pkg::ST_OK && result.result_numerator == '0
		&& result.result_denominator == '0)
		else $error("compare result carries a fraction");

	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == rau_pkg::ST_OK && result.result_numerator != '0 |->
		result.result_denominator != '0)
		else $error("nonzero result with zero denominator");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (.*);

// ===== tb/tb_rational_arithmetic_unit_top.sv =====
// Testbench for the rational arithmetic unit: random and directed fractions, scoreboarded.
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit_top;

	localparam int NUM_RANDOM = 1900;
	localparam longint NUM_MAX = (64'sd1 <<< (rau_pkg::VALUE_WIDTH - 1)) - 1;
	localparam longint NUM_MIN = -(64'sd1 <<< (rau_pkg::VALUE_WIDTH - 1));

	// Expected fractions, oldest first; mismatches reported as they come.
	class fraction_scoreboard;
		rau_pkg::result_t pending_q[$];
		int               fail_count;

		function rau_pkg::result_t work_out(rau_pkg::item_t it);
			rau_pkg::result_t r;
			longint  a, b, c, d, rn, rd, t;
			longint unsigned nm, dm, x, y;
			logic    neg;
			r = '0;
			r.status = rau_pkg::ST_OK;
			a = it.lhs_numerator;
			b = {33'd0, it.lhs_denominator};
			c = it.rhs_numerator;
			d = {33'd0, it.rhs_denominator};
			if (it.operation == rau_pkg::OP_CMP) begin
				r.is_equal = (a == c) && (b == d);
				return r;
			end
			if (it.operation > rau_pkg::OP_CMP)
				return r;
			case (it.operation)
				rau_pkg::OP_ADD: begin
					rn = a * d + c * b;
					rd = b * d;
				end
				rau_pkg::OP_SUB: begin
					rn = a * d - c * b;
					rd = b * d;
				end
				rau_pkg::OP_MUL: begin
					rn = a * c;
					rd = b * d;
				end
				default: begin
					rn = a * d;
					rd = b * c;
				end
			endcase
			if (rd == 0) begin
				r.status = rau_pkg::ST_DIVZ;
				return r;
			end
			if (rn == 0) begin
				r.result_denominator = 31'd1;
				return r;
			end
			neg = (rn < 0) != (rd < 0);
			nm = (rn < 0) ? -rn : rn;
			dm = (rd < 0) ? -rd : rd;
			x = nm;
			y = dm;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			nm = nm / x;
			dm = dm / x;
			if ((neg ? nm > 64'd1 << (rau_pkg::VALUE_WIDTH - 1) : nm > NUM_MAX)
				|| dm > NUM_MAX) begin
				r.status = rau_pkg::ST_OVF;
				return r;
			end
			r.result_numerator = 32'(neg ? -nm : nm);
			r.result_denominator = 31'(dm);
			return r;
		endfunction

		function void note_item(rau_pkg::item_t it);
			pending_q.push_back(work_out(it));
		endfunction

		function void check_result(rau_pkg::result_t got);
			rau_pkg::result_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				fail_count++;
				return;
			end
			want = pending_q.pop_front();
			if (got.result_numerator !== want.result_numerator) begin
				$display("%0t: numerator expected %0d got %0d", $time,
					want.result_numerator, got.result_numerator);
				fail_count++;
			end
			if (got.result_denominator !== want.result_denominator) begin
				$display("%0t: denominator expected %0d got %0d", $time,
					want.result_denominator, got.result_denominator);
				fail_count++;
			end
			if (got.is_equal !== want.is_equal) begin
				$display("%0t: is_equal expected %b got %b", $time,
					want.is_equal, got.is_equal);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time,
					want.status, got.status);
				fail_count++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	rau_pkg::item_t   item;
	logic             result_valid;
	logic             result_stall;
	rau_pkg::result_t result;

	fraction_scoreboard fractions;

	rational_arithmetic_unit_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Draw a numerator: half the time small, else extreme, zero or fully random.
	function automatic logic [31:0] pick_numerator();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3, 4: return $urandom;
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	function automatic logic [30:0] pick_denominator();
		case ($urandom_range(0, 9))
			0: return 31'h7fff_ffff;
			1: return 31'd1;
			2: return 31'd0;
			3, 4: return 31'($urandom);
			default: return 31'($urandom_range(1, 1000));
		endcase
	endfunction

	// Present one item after a random gap and hold it until the transfer.
	task automatic send_item(rau_pkg::item_t it);
		int gap;
		gap = $urandom_range(0, 18);
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		fractions.note_item(it);
	endtask

	// Drop valid and hold off until every expected result has come.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (fractions.pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_fields(logic [2:0] op, logic [31:0] a, logic [30:0] b,
			logic [31:0] c, logic [30:0] d);
		rau_pkg::item_t it;
		it.operation = op;
		it.lhs_numerator = a;
		it.lhs_denominator = b;
		it.rhs_numerator = c;
		it.rhs_denominator = d;
		send_item(it);
	endtask

	// Stall the result side at random, with stall-free stretches.
	initial begin
		int gap;
		result_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			if (gap != 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			result_stall <= 1'b0;
			// hold the stall low until a transfer has gone through
			do
				@(posedge clk);
			while (!result_valid);
		end
	end

	// Check every transfer on the result side at the rising edge.
	always @(posedge clk)
		if (arst_n && result_valid && !result_stall)
			fractions.check_result(result);

	initial begin
		rau_pkg::item_t it;
		fractions = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every operation, extremes, division by zero, overflow
		for (int op = 0; op < 8; op++)
			send_fields(3'(op), 32'd3, 31'd4, 32'hffff_fffb, 31'd6);
		send_fields(rau_pkg::OP_DIV, 32'd7, 31'd2, 32'd0, 31'd5);
		send_fields(rau_pkg::OP_ADD, 32'd1, 31'd0, 32'd1, 31'd3);
		send_fields(rau_pkg::OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
		send_fields(rau_pkg::OP_MUL, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
		send_fields(rau_pkg::OP_DIV, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
		send_fields(rau_pkg::OP_ADD, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff,
			31'h7fff_fffe);
		send_fields(rau_pkg::OP_SUB, 32'd5, 31'd9, 32'd5, 31'd9);
		send_fields(rau_pkg::OP_MUL, 32'd6, 31'd4, 32'd2, 31'd3);
		send_fields(rau_pkg::OP_CMP, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000,
			31'h7fff_ffff);
		send_fields(rau_pkg::OP_CMP, 32'd1, 31'd2, 32'd2, 31'd4);
		send_fields(rau_pkg::OP_DIV, 32'd1, 31'h7fff_ffff, 32'h7fff_ffff, 31'd1);

		// let the block drain before the random part
		drain();

		for (int n = 0; n < NUM_RANDOM; n++) begin
			it.operation = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			it.lhs_numerator = pick_numerator();
			it.lhs_denominator = pick_denominator();
			it.rhs_numerator = pick_numerator();
			it.rhs_denominator = pick_denominator();
			if (it.operation == rau_pkg::OP_CMP && $urandom_range(0, 2) == 0) begin
				it.rhs_numerator = it.lhs_numerator;
				it.rhs_denominator = it.lhs_denominator;
			end
			send_item(it);
			if (n == NUM_RANDOM / 2)
				drain();
		end

		drain();
		repeat (400) @(posedge clk);
		if (fractions.fail_count == 0)
			$display("rational_arithmetic_unit_top regression: pass");
		else
			$display("rational_arithmetic_unit_top regression: fail");
		$finish;
	end

	// Worst case: ~2000 items, each with its busy time and its input and result stall gaps, x 4 ns, taken several times.
	initial begin
		#20_000_000;
		$display("rational_arithmetic_unit_top regression: fail");
		$finish;
	end

endmodule
